@@ hw/rtl/dse_pkg.sv @@
// Package for the deck shuffle engine: deck size, field widths and the
// command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package dse_pkg;

	localparam int DECK_SIZE = 52;
	localparam int DRAW_W    = 31;
	localparam int CARD_W    = 7;
	localparam int SLOT_W    = 6;
	localparam int IDX_W     = $clog2(DECK_SIZE);
	localparam int DIV_W     = $clog2(DECK_SIZE + 1);
	localparam int CNT_W     = $clog2(DRAW_W);

	typedef struct packed {
		logic load;
		logic div_step;
		logic rd_swap;
		logic wr_i;
		logic wr_j;
		logic emit_rd;
	} dse_cmd_t;

	typedef struct packed {
		logic div_last;
		logic pos_last;
		logic emit_last;
	} dse_stat_t;

endpackage

@@ hw/rtl/dse_ctrl.sv @@
// Controller state machine of the deck shuffle engine.
// Depends on dse_pkg for the command and status structs.
`timescale 1ns / 1ps

module dse_ctrl
	import dse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dse_stat_t stat,
	output dse_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_WR_I  = 3'd3;
	localparam logic [2:0] S_WR_J  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_swap = 1'b1;
				state_d     = S_WR_I;
			end
			S_WR_I: begin
				cmd.wr_i = 1'b1;
				state_d  = S_WR_J;
			end
			S_WR_J: begin
				cmd.wr_j = 1'b1;
				state_d  = stat.pos_last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				cmd.emit_rd = 1'b1;
				if (stat.emit_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/dse_datapath.sv @@
// Datapath of the deck shuffle engine: bit-serial remainder unit, position
// and slot counters, deck memory with reset valid bits, result register.
// Depends on dse_pkg for widths and the command and status structs.
`timescale 1ns / 1ps

module dse_datapath
	import dse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dse_cmd_t          cmd,
	output dse_stat_t         stat,
	input  logic [DRAW_W-1:0] random_draw,
	output logic              strobe,
	output logic [CARD_W-1:0] card_value,
	output logic [SLOT_W-1:0] card_slot,
	output logic              last_card
);

	logic [DRAW_W-1:0] draw_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic [CARD_W-1:0] rda_q;
	logic [CARD_W-1:0] rdb_q;
	logic              emit_s1;
	logic [IDX_W-1:0]  slot_s1;
	logic [DECK_SIZE-1:0] vld_q;
	logic [CARD_W-1:0] mem [DECK_SIZE];

	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    trial_sub;
	logic [IDX_W:0]    j_sum;
	logic [IDX_W-1:0]  j_idx;
	logic [IDX_W-1:0]  rda_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CARD_W-1:0] wr_data;

	assign trial     = {rem_q, draw_q[DRAW_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};

	assign j_sum = {1'b0, pos_q} + (IDX_W+1)'(rem_q);
	assign j_idx = (j_sum >= (IDX_W+1)'(DECK_SIZE)) ? IDX_W'(DECK_SIZE - 1)
		: j_sum[IDX_W-1:0];

	assign rda_addr = cmd.emit_rd ? k_q : pos_q;
	assign wr_en    = cmd.wr_i | cmd.wr_j;
	assign wr_addr  = cmd.wr_i ? pos_q : j_q;
	assign wr_data  = cmd.wr_i ? rdb_q : rda_q;

	assign stat.div_last  = (cnt_q == '0);
	assign stat.pos_last  = (pos_q == IDX_W'(DECK_SIZE - 1));
	assign stat.emit_last = (k_q == IDX_W'(DECK_SIZE - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			draw_q    <= random_draw;
			rem_q     <= '0;
			divisor_q <= DIV_W'(DECK_SIZE) - DIV_W'(pos_q);
		end else if (cmd.div_step) begin
			draw_q <= {draw_q[DRAW_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				rem_q <= trial_sub[DIV_W-1:0];
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
		if (cmd.rd_swap) begin
			j_q <= j_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pos_q   <= '0;
			k_q     <= '0;
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= cmd.emit_rd;
			if (cmd.load) begin
				cnt_q <= CNT_W'(DRAW_W - 1);
			end else if (cmd.div_step && (cnt_q != '0)) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.wr_j) begin
				pos_q <= stat.pos_last ? '0 : pos_q + 1'b1;
			end
			if (cmd.emit_rd) begin
				k_q <= stat.emit_last ? '0 : k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_swap || cmd.emit_rd) begin
			rda_q <= vld_q[rda_addr] ? mem[rda_addr] : CARD_W'(rda_addr) + 1'b1;
		end
		if (cmd.rd_swap) begin
			rdb_q <= vld_q[j_idx] ? mem[j_idx] : CARD_W'(j_idx) + 1'b1;
		end
		if (cmd.emit_rd) begin
			slot_s1 <= k_q;
		end
	end

	assign strobe     = emit_s1;
	assign card_value = rda_q;
	assign card_slot  = SLOT_W'(slot_s1);
	assign last_card  = emit_s1 && (slot_s1 == IDX_W'(DECK_SIZE - 1));

endmodule

@@ hw/rtl/deck_shuffle_engine.sv @@
// Top level of the deck shuffle engine: Fisher-Yates shuffle of the deck.
// Depends on dse_pkg, dse_ctrl and dse_datapath.
//
//   channel   signals                                   direction
//   request   start, busy, random_draw                  in (busy out)
//   result    strobe, card_value, card_slot, last_card  out
//
// After the accepting edge busy stays high through the controller states DIV, the
// bit-serial remainder of the draw, READ, which reads both deck entries, and WR_I
// and WR_J, which write them back through the one write port. The next request
// is accepted once busy is low again. A request that completes a pass then reads
// the deck out in states EMIT and DRAIN, one card per cycle on strobe.
// Reset puts the deck in order 1 to N through per-entry valid bits, at once.
// The receiver cannot stall; results are not held back.
`timescale 1ns / 1ps

module deck_shuffle_engine
	import dse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DRAW_W-1:0] random_draw,
	output logic              strobe,
	output logic [CARD_W-1:0] card_value,
	output logic [SLOT_W-1:0] card_slot,
	output logic              last_card
);

	dse_cmd_t  cmd;
	dse_stat_t stat;

	dse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	dse_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.random_draw (random_draw),
		.strobe      (strobe),
		.card_value  (card_value),
		.card_slot   (card_slot),
		.last_card   (last_card)
	);

`ifndef ASSERT_OFF
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe outside a busy period");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_card |-> strobe)
		else $error("last card flag without a result");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_card) |=> strobe)
		else $error("card burst broken before the last card");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");
`endif

endmodule
